@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the selective-repeat sender.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SRS_ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SRS_ASSERT_IMPLIES(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define SRS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/srs_pkg.sv @@
// Shared types and codes for the selective-repeat sender.
// No dependencies; used by srs_out_reg and selective_repeat_sender_core.
`timescale 1ns / 1ps

package srs_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_POLL    = 2'd0;
    localparam logic [1:0] REQ_ACK     = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_TOTAL_FRAMES   = 2'd0;
    localparam logic [1:0] REG_WINDOW_LIMIT   = 2'd1;
    localparam logic [1:0] REG_FIRST_SEQUENCE = 2'd2;

    // Widths of the configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // At most this many results are produced by one poll.
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = 6;

    // One input item.
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] ack_sequence;
    } req_t;

    // One result item.
    typedef struct packed {
        logic        has_frame;
        logic [31:0] frame_number;
        logic [7:0]  frame_sequence;
        logic        is_resend;
        logic        ack_matched;
        logic        transfer_done;
        logic        last_result;
    } res_t;

endpackage

@@ hdl/selective_repeat_sender_core.sv @@
// Selective-repeat ARQ sender window core with its configuration registers.
// Depends on srs_pkg, srs_out_reg and assert_macros.svh.
//
// Use:
// Requests enter on s_valid/s_ready/s_data: a poll, an ack or a timeout. Each
// request produces one or more result items on m_valid/m_ready/m_data; the
// final result of a request has last_result set. Registers are written through
// cfg_wr_en/cfg_index/cfg_wdata while no request is in progress; the user must
// keep to this, as the block itself does not enforce it. A small sequencer
// walks the in-flight slots one per cycle, while the output register has room
// for its results, with a shared counter and sequence compare. A poll walks
// them for retransmissions and then emits new frames, an ack scans them for a
// match and slides the base, and a timeout marks them, each before its final result.
// s_ready is high only between requests.
// Poll results are staged one deep so that the last one can be flagged; a
// result waits in the output register while the receiver stalls, and the
// sequencer stops until there is room.
// After reset the window is empty, all slot flags are clear, total_frames is
// 0, window_limit is 1 and first_sequence is 0.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module selective_repeat_sender_core #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [srs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  srs_pkg::req_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output srs_pkg::res_t                     m_data
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESEND,
        ST_NEWF,
        ST_ACK_SCAN,
        ST_ACK_SLIDE,
        ST_TMO,
        ST_FINISH
    } state_t;

    // Configuration registers.
    logic [31:0]      total_frames_reg;
    logic [CNT_W-1:0] window_limit_reg;
    logic [7:0]       first_seq_reg;
    logic [6:0]       lim_raw;
    logic [CNT_W-1:0] lim_clamp;

    // Window state.
    logic [31:0]           base_reg;
    logic [SLOT_W-1:0]     base_slot_reg;
    logic [31:0]           next_reg;
    logic [SLOT_W-1:0]     next_slot_reg;
    logic [CNT_W-1:0]      inflight_reg;
    logic [MAX_WINDOW-1:0] acked_reg;
    logic [MAX_WINDOW-1:0] resend_reg;

    // Sequencer state.
    state_t                       state_reg;
    logic [7:0]                   ack_seq_reg;
    logic [31:0]                  scan_idx_reg;
    logic [SLOT_W-1:0]            scan_slot_reg;
    logic [CNT_W-1:0]             scan_cnt_reg;
    logic [srs_pkg::RES_CNT_W-1:0] res_cnt_reg;
    logic                         matched_reg;
    logic                         pend_valid_reg;
    srs_pkg::res_t                pend_reg;

    // Sequencer datapath signals.
    logic              out_free;
    logic              out_load;
    srs_pkg::res_t     out_data;
    logic              can_emit;
    logic              done_now;
    logic [7:0]        scan_seq;
    logic [7:0]        new_seq;
    logic              scan_end;
    logic              res_full;
    logic              new_ok;
    logic [SLOT_W-1:0] scan_slot_inc;
    logic [SLOT_W-1:0] base_slot_inc;
    logic [SLOT_W-1:0] next_slot_inc;
    srs_pkg::res_t     cand;

    // Clamp a window write into 1..MAX_WINDOW.
    assign lim_raw = {1'b0, cfg_wdata[5:0]};

    always_comb begin
        if (lim_raw == 7'd0) begin
            lim_clamp = CNT_W'(1);
        end else if (lim_raw > 7'(MAX_WINDOW)) begin
            lim_clamp = CNT_W'(MAX_WINDOW);
        end else begin
            lim_clamp = CNT_W'(lim_raw);
        end
    end

    // Configuration register writes; an unused index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_frames_reg <= '0;
            window_limit_reg <= CNT_W'(1);
            first_seq_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                srs_pkg::REG_TOTAL_FRAMES:   total_frames_reg <= cfg_wdata;
                srs_pkg::REG_WINDOW_LIMIT:   window_limit_reg <= lim_clamp;
                srs_pkg::REG_FIRST_SEQUENCE: first_seq_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Ring slot successors.
    assign scan_slot_inc = (scan_slot_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                                        : scan_slot_reg + 1'b1;
    assign base_slot_inc = (base_slot_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                                        : base_slot_reg + 1'b1;
    assign next_slot_inc = (next_slot_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                                        : next_slot_reg + 1'b1;

    // Shared compare and sequence logic.
    assign done_now = (base_reg >= total_frames_reg);
    assign scan_seq = first_seq_reg + scan_idx_reg[7:0];
    assign new_seq  = first_seq_reg + next_reg[7:0];
    assign scan_end = (scan_cnt_reg == inflight_reg);
    assign res_full = (res_cnt_reg == srs_pkg::RES_CNT_W'(srs_pkg::MAX_RESULTS));
    assign new_ok   = !res_full && (next_reg < total_frames_reg)
                      && (inflight_reg < window_limit_reg);
    assign can_emit = !pend_valid_reg || out_free;

    // Frame result built in the current step.
    always_comb begin
        cand               = '0;
        cand.has_frame     = 1'b1;
        cand.transfer_done = done_now;
        if (state_reg == ST_RESEND) begin
            cand.frame_number   = scan_idx_reg;
            cand.frame_sequence = scan_seq;
            cand.is_resend      = 1'b1;
        end else begin
            cand.frame_number   = next_reg;
            cand.frame_sequence = new_seq;
        end
    end

    // Output register load: a staged item moves out when a newer one arrives,
    // and the final item of a request is flagged as last.
    always_comb begin
        out_load = 1'b0;
        out_data = pend_reg;
        if (state_reg == ST_FINISH) begin
            out_load = out_free;
            if (pend_valid_reg) begin
                out_data.last_result = 1'b1;
            end else begin
                out_data               = '0;
                out_data.ack_matched   = matched_reg;
                out_data.transfer_done = done_now;
                out_data.last_result   = 1'b1;
            end
        end else if (state_reg == ST_RESEND) begin
            out_load = pend_valid_reg && out_free && !scan_end && !res_full
                       && resend_reg[scan_slot_reg];
        end else if (state_reg == ST_NEWF) begin
            out_load = pend_valid_reg && out_free && new_ok;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer and window state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            base_reg       <= '0;
            base_slot_reg  <= '0;
            next_reg       <= '0;
            next_slot_reg  <= '0;
            inflight_reg   <= '0;
            acked_reg      <= '0;
            resend_reg     <= '0;
            pend_valid_reg <= 1'b0;
            matched_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ack_seq_reg   <= s_data.ack_sequence;
                        scan_idx_reg  <= base_reg;
                        scan_slot_reg <= base_slot_reg;
                        scan_cnt_reg  <= '0;
                        res_cnt_reg   <= '0;
                        matched_reg   <= 1'b0;
                        unique case (s_data.req_type)
                            srs_pkg::REQ_POLL:    state_reg <= ST_RESEND;
                            srs_pkg::REQ_ACK:     state_reg <= ST_ACK_SCAN;
                            srs_pkg::REQ_TIMEOUT: state_reg <= ST_TMO;
                            default:              state_reg <= ST_FINISH;
                        endcase
                    end
                end

                // Pending retransmissions in index order.
                ST_RESEND: begin
                    if (scan_end || res_full) begin
                        state_reg <= ST_NEWF;
                    end else if (!resend_reg[scan_slot_reg] || can_emit) begin
                        if (resend_reg[scan_slot_reg]) begin
                            resend_reg[scan_slot_reg] <= 1'b0;
                            pend_reg       <= cand;
                            pend_valid_reg <= 1'b1;
                            res_cnt_reg    <= res_cnt_reg + 1'b1;
                        end
                        scan_idx_reg  <= scan_idx_reg + 32'd1;
                        scan_slot_reg <= scan_slot_inc;
                        scan_cnt_reg  <= scan_cnt_reg + 1'b1;
                    end
                end

                // New frames while the window and the transfer allow.
                ST_NEWF: begin
                    if (!new_ok) begin
                        state_reg <= ST_FINISH;
                    end else if (can_emit) begin
                        acked_reg[next_slot_reg]  <= 1'b0;
                        resend_reg[next_slot_reg] <= 1'b0;
                        pend_reg       <= cand;
                        pend_valid_reg <= 1'b1;
                        res_cnt_reg    <= res_cnt_reg + 1'b1;
                        next_reg       <= next_reg + 32'd1;
                        next_slot_reg  <= next_slot_inc;
                        inflight_reg   <= inflight_reg + 1'b1;
                    end
                end

                // Find the first unacked in-flight frame with a matching sequence.
                ST_ACK_SCAN: begin
                    if (scan_end) begin
                        state_reg <= ST_FINISH;
                    end else if (!acked_reg[scan_slot_reg] && scan_seq == ack_seq_reg) begin
                        acked_reg[scan_slot_reg]  <= 1'b1;
                        resend_reg[scan_slot_reg] <= 1'b0;
                        matched_reg <= 1'b1;
                        state_reg   <= ST_ACK_SLIDE;
                    end else begin
                        scan_idx_reg  <= scan_idx_reg + 32'd1;
                        scan_slot_reg <= scan_slot_inc;
                        scan_cnt_reg  <= scan_cnt_reg + 1'b1;
                    end
                end

                // Slide the base past acknowledged frames, one per cycle.
                ST_ACK_SLIDE: begin
                    if (inflight_reg != '0 && acked_reg[base_slot_reg]) begin
                        base_reg      <= base_reg + 32'd1;
                        base_slot_reg <= base_slot_inc;
                        inflight_reg  <= inflight_reg - 1'b1;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end

                // Mark every unacked in-flight frame for retransmission.
                ST_TMO: begin
                    if (scan_end) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        if (!acked_reg[scan_slot_reg]) begin
                            resend_reg[scan_slot_reg] <= 1'b1;
                        end
                        scan_idx_reg  <= scan_idx_reg + 32'd1;
                        scan_slot_reg <= scan_slot_inc;
                        scan_cnt_reg  <= scan_cnt_reg + 1'b1;
                    end
                end

                // Deliver the final item of the request.
                ST_FINISH: begin
                    if (out_free) begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    srs_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .load_data (out_data),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // The window never holds more frames than there are slots.
    `SRS_ASSERT_ALWAYS(a_inflight_bound, aclk, aresetn, inflight_reg <= CNT_W'(MAX_WINDOW), "in-flight count exceeds ring size")

    // No staged poll item may be left over when a new request can enter.
    `SRS_ASSERT_IMPLIES(a_idle_no_pending, aclk, aresetn, s_ready, !pend_valid_reg, "staged item left at idle")

    // An accepted request always starts the sequencer.
    `SRS_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, state_reg != ST_IDLE, "accepted item did not start work")

    // A result without a frame is always the final one of its request.
    `SRS_ASSERT_IMPLIES(a_empty_is_last, aclk, aresetn, m_valid && !m_data.has_frame, m_data.last_result, "frameless result not last")

endmodule

@@ hdl/srs_out_reg.sv @@
// Output register of the selective-repeat sender: holds one result item
// until the downstream side takes it. Depends on srs_pkg.
`timescale 1ns / 1ps

module srs_out_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  srs_pkg::res_t load_data,
    output logic          free,
    output logic          m_valid,
    input  logic          m_ready,
    output srs_pkg::res_t m_data
);

    logic          valid_reg;
    srs_pkg::res_t data_reg;

    // The register can take a new item when empty or when its item leaves now.
    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (free && load) begin
            data_reg <= load_data;
        end
    end

endmodule
